[rtl/pfc_pkg.sv]
// Shared types and constants for the IP pair flow counter.
package pfc_pkg;

   // Table geometry and count width
   localparam int TABLE_DEPTH = 64;
   localparam int COUNT_BITS  = 32;
   localparam int SLOT_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int USED_BITS   = $clog2(TABLE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(TABLE_DEPTH - 1);

   // Operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] pair_src;
      logic [31:0] pair_dst;
      logic [31:0] pair_count;
      logic [5:0]  slot_or_rank;
      logic        was_new;
      logic        table_full;
      logic        last;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic [31:0]           src;
      logic [31:0]           dst;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Item moving through the sort chain
   typedef struct packed {
      logic                 valid;
      logic [SLOT_BITS-1:0] slot;
      entry_type            entry;
   } sort_item_type;

   // Broadcast control to the table cells
   typedef struct packed {
      logic        lookup;
      logic        bump;
      logic        insert;
      logic        rotate;
      logic [31:0] key_src;
      logic [31:0] key_dst;
   } table_ctrl_type;

   // Broadcast control to the sort cells
   typedef struct packed {
      logic clear;
      logic run;
      logic drain;
   } sort_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESP,
      ST_FEED,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

[rtl/pfc_table_cell.sv]
// One table cell: holds an entry, matches the key, bumps its count, takes a new key, rotates.
module pfc_table_cell
   import pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  table_ctrl_type        ctrl,
   input  logic                  live,
   input  logic                  sel_new,
   input  entry_type             shift_in,
   output entry_type             entry_out,
   output logic                  hit,
   output logic [COUNT_BITS-1:0] bumped
);

   entry_type entry_ff, entry_in;
   logic      hit_ff, hit_in;

   // Saturating increment of the held count
   assign bumped = (entry_ff.count == COUNT_MAX) ? entry_ff.count
                                                 : entry_ff.count + COUNT_BITS'(1);

   // Update entry and hit flag
   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      if (ctrl.lookup) begin
         hit_in = live && (entry_ff.src == ctrl.key_src) && (entry_ff.dst == ctrl.key_dst);
      end
      if (ctrl.rotate) begin
         entry_in = shift_in;
      end else if (sel_new) begin
         entry_in.src   = ctrl.key_src;
         entry_in.dst   = ctrl.key_dst;
         entry_in.count = COUNT_BITS'(1);
      end else if (ctrl.bump && hit_ff) begin
         entry_in.count = bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign hit       = hit_ff;

endmodule

[rtl/pfc_sort_cell.sv]
// One sort cell: keeps the best item seen, passes the other one on, shifts out on drain.
module pfc_sort_cell
   import pfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sort_ctrl_type ctrl,
   input  sort_item_type item_in,
   input  sort_item_type drain_in,
   output sort_item_type held,
   output sort_item_type pass
);

   sort_item_type held_ff, held_in;
   sort_item_type pass_ff, pass_in;
   logic          take;

   // Higher count wins, equal counts go by lower slot
   assign take = item_in.valid &&
                 (!held_ff.valid ||
                  (item_in.entry.count > held_ff.entry.count) ||
                  ((item_in.entry.count == held_ff.entry.count) &&
                   (item_in.slot < held_ff.slot)));

   always_comb begin
      held_in = held_ff;
      pass_in = pass_ff;
      priority if (ctrl.clear) begin
         held_in = '0;
         pass_in = '0;
      end else if (ctrl.drain) begin
         held_in = drain_in;
         pass_in = '0;
      end else if (ctrl.run) begin
         if (take) begin
            held_in = item_in;
            pass_in = held_ff;
         end else begin
            pass_in = item_in;
         end
      end else begin
         // Hold both registers while the chain is idle
         held_in = held_ff;
         pass_in = pass_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

[rtl/ip_pair_flow_counter.sv]
// Top level: table cell row, sort cell row and the sequencer between them.
// Record: the key is looked up in LOOKUP, bumped or inserted in UPDATE and sent as one result beat from RESP;
// the next request is taken back in IDLE. Dump: the table rotates through the sort chain in FEED,
// the chain settles in SETTLE, then DRAIN streams one beat per cycle while the output is not stalled.
// Empty-table dump: a single beat with last set, sent from RESP.
// One request is in work at a time.
// Reset clears the entry count and control state; table contents are not cleared.
module ip_pair_flow_counter
   import pfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type            state_ff, state_in;
   logic [USED_BITS-1:0] used_ff, used_in;
   logic [31:0]          key_src_ff, key_src_in;
   logic [31:0]          key_dst_ff, key_dst_in;
   logic [SLOT_BITS-1:0] phase_ff, phase_in;
   logic [SLOT_BITS-1:0] rank_ff, rank_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   table_ctrl_type        tctrl;
   sort_ctrl_type         sctrl;
   sort_item_type         feed;
   entry_type             tbl_entry  [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] tbl_bumped [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] tbl_hit;
   sort_item_type         srt_held   [TABLE_DEPTH];
   sort_item_type         srt_pass   [TABLE_DEPTH];

   logic                  any_hit;
   logic [SLOT_BITS-1:0]  hit_slot;
   logic [COUNT_BITS-1:0] hit_count;
   logic                  out_free;
   logic                  drain_last;

   // Table cell row, rotating toward cell zero
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_table
      pfc_table_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (tctrl),
         .live      (USED_BITS'(i) < used_ff),
         .sel_new   (tctrl.insert && (USED_BITS'(i) == used_ff)),
         .shift_in  (tbl_entry[(i + 1) % TABLE_DEPTH]),
         .entry_out (tbl_entry[i]),
         .hit       (tbl_hit[i]),
         .bumped    (tbl_bumped[i])
      );
   end

   // Sort cell row, fed at cell zero and drained from cell zero
   for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_sort
      sort_item_type item_in;
      sort_item_type drain_in;
      if (j == 0) begin : g_head
         assign item_in = feed;
      end else begin : g_body
         assign item_in = srt_pass[j-1];
      end
      if (j == TABLE_DEPTH - 1) begin : g_tail
         assign drain_in = '0;
      end else begin : g_next
         assign drain_in = srt_held[j+1];
      end
      pfc_sort_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (sctrl),
         .item_in  (item_in),
         .drain_in (drain_in),
         .held     (srt_held[j]),
         .pass     (srt_pass[j])
      );
   end

   // Collapse the one-hot hit row into slot and updated count
   always_comb begin
      any_hit   = |tbl_hit;
      hit_slot  = '0;
      hit_count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_hit[i]) begin
            hit_slot  = hit_slot | SLOT_BITS'(i);
            hit_count = hit_count | tbl_bumped[i];
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign drain_last = (USED_BITS'(rank_ff) == (used_ff - USED_BITS'(1)));

   // Feed the sort chain from table cell zero in slot order
   always_comb begin
      feed.valid = (state_ff == ST_FEED) && (USED_BITS'(phase_ff) < used_ff);
      feed.slot  = phase_ff;
      feed.entry = tbl_entry[0];
   end

   // Sequencer: next state and control
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      key_src_in   = key_src_ff;
      key_dst_in   = key_dst_ff;
      phase_in     = phase_ff;
      rank_in      = rank_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      tctrl        = '0;
      tctrl.key_src = key_src_ff;
      tctrl.key_dst = key_dst_ff;
      sctrl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_src_in = req_data.src_addr;
               key_dst_in = req_data.dst_addr;
               if (req_data.op == OP_RECORD) begin
                  state_in = ST_LOOKUP;
               end else if (used_ff == '0) begin
                  res_in      = '0;
                  res_in.last = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  sctrl.clear = 1'b1;
                  phase_in    = '0;
                  state_in    = ST_FEED;
               end
            end
         end
         ST_LOOKUP: begin
            tctrl.lookup = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            res_in          = '0;
            res_in.pair_src = key_src_ff;
            res_in.pair_dst = key_dst_ff;
            res_in.last     = 1'b1;
            if (any_hit) begin
               tctrl.bump          = 1'b1;
               res_in.entry_valid  = 1'b1;
               res_in.pair_count   = 32'(hit_count);
               res_in.slot_or_rank = 6'(hit_slot);
            end else if (used_ff < USED_BITS'(TABLE_DEPTH)) begin
               tctrl.insert        = 1'b1;
               used_in             = used_ff + USED_BITS'(1);
               res_in.entry_valid  = 1'b1;
               res_in.pair_count   = 32'd1;
               res_in.slot_or_rank = 6'(used_ff);
               res_in.was_new      = 1'b1;
            end else begin
               res_in.table_full = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FEED: begin
            tctrl.rotate = 1'b1;
            sctrl.run    = 1'b1;
            if (phase_ff == LAST_SLOT) begin
               phase_in = '0;
               state_in = ST_SETTLE;
            end else begin
               phase_in = phase_ff + SLOT_BITS'(1);
            end
         end
         ST_SETTLE: begin
            sctrl.run = 1'b1;
            if (phase_ff == LAST_SLOT) begin
               rank_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               phase_in = phase_ff + SLOT_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_in              = '0;
               rsp_in.entry_valid  = 1'b1;
               rsp_in.pair_src     = srt_held[0].entry.src;
               rsp_in.pair_dst     = srt_held[0].entry.dst;
               rsp_in.pair_count   = 32'(srt_held[0].entry.count);
               rsp_in.slot_or_rank = 6'(rank_ff);
               rsp_in.last         = drain_last;
               rsp_valid_in        = 1'b1;
               sctrl.drain         = 1'b1;
               if (drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rank_in = rank_ff + SLOT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         phase_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         phase_ff     <= phase_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_src_ff <= key_src_in;
      key_dst_ff <= key_dst_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
